FILE: rtl/core/signed_divider_binary_search_top_assert.svh
// Assertion macros for the signed divider checker.
`ifndef SIGNED_DIVIDER_BINARY_SEARCH_TOP_ASSERT_SVH
`define SIGNED_DIVIDER_BINARY_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SDIV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sdiv checker: property violated");

// Next-cycle implication, disabled in reset.
`define SDIV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sdiv checker: property violated");

`endif

FILE: rtl/core/sdiv_pkg.sv
// Shared constants and types for the signed divider.
`default_nettype none

package sdiv_pkg;

  localparam int unsigned FieldWidth       = 32;
  localparam int unsigned DataWidthDefault = 32;

  typedef struct packed {
    logic valid;
    logic neg;
    logic dz;
  } sdiv_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdiv_in_if.sv
// Input channel: dividend and divisor word with valid/ready.
`default_nettype none

interface sdiv_in_if
  import sdiv_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] numerator;
  logic [FieldWidth-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sdiv_out_if.sv
// Output channel: quotient word and zero-divisor flag with valid/ready.
`default_nettype none

interface sdiv_out_if
  import sdiv_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] quotient;
  logic                  zero_divisor;

  modport source (output valid, output quotient, output zero_divisor, input ready);
  modport sink   (input valid, input quotient, input zero_divisor, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sdiv_step.sv
// One restoring divide stage: compare, subtract and shift in one quotient bit.
`default_nettype none

module sdiv_step
  import sdiv_pkg::*;
#(
  parameter int unsigned Width = DataWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  sdiv_ctrl_t       ctrl_i,
  input  logic [Width-1:0] rem_i,
  input  logic [Width-1:0] nq_i,
  input  logic [Width-1:0] den_i,
  output sdiv_ctrl_t       ctrl_o,
  output logic [Width-1:0] rem_o,
  output logic [Width-1:0] nq_o,
  output logic [Width-1:0] den_o
);

  logic [Width:0]   trial;
  logic [Width:0]   diff;
  logic             ge;
  logic [Width-1:0] rem_d, nq_d;
  sdiv_ctrl_t       ctrl_q;
  logic [Width-1:0] rem_q, nq_q, den_q;

  always_comb begin
    trial = {rem_i, nq_i[Width-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[Width-1:0] : trial[Width-1:0];
    nq_d  = {nq_i[Width-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign den_o  = den_q;

endmodule

`default_nettype wire

FILE: rtl/core/signed_divider_binary_search_top.sv
// Signed divider top level: magnitude stage, restoring divide pipeline, sign fix-up.
// Pipeline from accepted word to result word:
//   one magnitude stage, one stage per quotient bit, one sign and saturation stage.
// Throughput: one word per cycle; the whole pipeline holds while the result is not taken.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
`default_nettype none

module signed_divider_binary_search_top
  import sdiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sdiv_in_if.sink           in_i,
  sdiv_out_if.source        out_o
);

  localparam int unsigned W = DataWidth;
  localparam logic [W-1:0] OneW   = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};

  logic             advance;
  logic [W-1:0]     num_w, den_w;
  sdiv_ctrl_t       ctrl_d;
  logic [W-1:0]     an_d, ad_d;

  sdiv_ctrl_t       ctrl_s [0:W];
  logic [W-1:0]     rem_s  [0:W];
  logic [W-1:0]     nq_s   [0:W];
  logic [W-1:0]     den_s  [0:W];

  sdiv_ctrl_t       ctrl0_q;
  logic [W-1:0]     an_q, ad_q;

  logic [W-1:0]          q_w;
  logic                  out_valid_q;
  logic [FieldWidth-1:0] quotient_d, quotient_q;
  logic                  zdiv_d, zdiv_q;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  // Take magnitudes and signs of the low DataWidth bits; flag a zero divisor.
  always_comb begin
    num_w        = in_i.numerator[W-1:0];
    den_w        = in_i.denominator[W-1:0];
    an_d         = num_w[W-1] ? W'(~num_w + OneW) : num_w;
    ad_d         = den_w[W-1] ? W'(~den_w + OneW) : den_w;
    ctrl_d.valid = in_i.valid;
    ctrl_d.neg   = num_w[W-1] ^ den_w[W-1];
    ctrl_d.dz    = ~|den_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
    end else if (advance) begin
      ctrl0_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      an_q <= an_d;
      ad_q <= ad_d;
    end
  end

  assign ctrl_s[0] = ctrl0_q;
  assign rem_s[0]  = '0;
  assign nq_s[0]   = an_q;
  assign den_s[0]  = ad_q;

  for (genvar g = 0; g < W; g++) begin : g_step
    sdiv_step #(
      .Width (W)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .ctrl_i (ctrl_s[g]),
      .rem_i  (rem_s[g]),
      .nq_i   (nq_s[g]),
      .den_i  (den_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .nq_o   (nq_s[g+1]),
      .den_o  (den_s[g+1])
    );
  end

  // Apply sign, saturate, flag zero divisor.
  always_comb begin
    if (ctrl_s[W].dz) begin
      q_w = MaxPos;
    end else if (ctrl_s[W].neg) begin
      q_w = W'(~nq_s[W] + OneW);
    end else if (nq_s[W][W-1]) begin
      q_w = MaxPos;
    end else begin
      q_w = nq_s[W];
    end
    quotient_d = FieldWidth'(signed'(q_w));
    zdiv_d     = ctrl_s[W].dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ctrl_s[W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      quotient_q <= quotient_d;
      zdiv_q     <= zdiv_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.quotient     = quotient_q;
  assign out_o.zero_divisor = zdiv_q;

endmodule

`default_nettype wire

FILE: rtl/core/sdiv_checker.sv
// Port-level checker for the signed divider and its bind to the top level.
`default_nettype none

`include "signed_divider_binary_search_top_assert.svh"

module sdiv_checker
  import sdiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [FieldWidth-1:0] quotient_i,
  input logic                  zero_divisor_i
);

  localparam logic [FieldWidth-1:0] MaxPosExt =
    FieldWidth'({1'b0, {(DataWidth-1){1'b1}}});

  logic sign_ext_ok;

  assign sign_ext_ok = (&quotient_i[FieldWidth-1:DataWidth-1]) ||
                       (~|quotient_i[FieldWidth-1:DataWidth-1]);

  `SDIV_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `SDIV_ASSERT_NOW(a_zero_div_max, clk_i, rst_ni, out_valid_i && zero_divisor_i, quotient_i == MaxPosExt)
  `SDIV_ASSERT_NOW(a_sign_extended, clk_i, rst_ni, out_valid_i, sign_ext_ok)
  `SDIV_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind signed_divider_binary_search_top sdiv_checker #(
  .DataWidth (DataWidth)
) u_sdiv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .quotient_i     (out_o.quotient),
  .zero_divisor_i (out_o.zero_divisor)
);

`default_nettype wire
